FILE: rtl/ldpcvn_pkg.sv
// ----------------------------------------------------------------------------
// ldpcvn_pkg
// shared types and constants of the ldpc variable node update
// ----------------------------------------------------------------------------
package ldpcvn_pkg;

    // width of the posterior llr result
    localparam int NODE_BITS = 12;

    // controller to datapath commands
    typedef struct packed {
        logic store;     // edge written to the buffers and summed
        logic first;     // first edge of the group, hold its channel llr
        logic rd_en;     // read buffer entry at the read index
        logic load_out;  // load the output register
        logic out_last;  // result being loaded closes the run
        logic clear;     // group done, clear running sum
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_free;  // output register can take a result this cycle
    } t_dp_status;

endpackage

FILE: rtl/ldpcvn_if.sv
// ----------------------------------------------------------------------------
// ldpcvn_in_if / ldpcvn_out_if
// valid/ready channels carrying edge requests and result requests
// ----------------------------------------------------------------------------
interface ldpcvn_in_if #(
    parameter int MSG_BITS = 10,
    parameter int TAG_BITS = 12
);
    logic                       valid;
    logic                       ready;
    logic signed [MSG_BITS-1:0] check_msg;
    logic signed [MSG_BITS-1:0] channel_llr;
    logic        [TAG_BITS-1:0] edge_tag;
    logic                       last_edge;

    modport source (output valid, check_msg, channel_llr, edge_tag, last_edge, input ready);
    modport sink   (input valid, check_msg, channel_llr, edge_tag, last_edge, output ready);
endinterface

interface ldpcvn_out_if #(
    parameter int MSG_BITS  = 10,
    parameter int TAG_BITS  = 12,
    parameter int NODE_BITS = 12
);
    logic                        valid;
    logic                        ready;
    logic signed [MSG_BITS-1:0]  var_msg;
    logic        [TAG_BITS-1:0]  out_tag;
    logic signed [NODE_BITS-1:0] node_llr;
    logic                        last_result;

    modport source (output valid, var_msg, out_tag, node_llr, last_result, input ready);
    modport sink   (input valid, var_msg, out_tag, node_llr, last_result, output ready);
endinterface

FILE: rtl/ldpc_variable_node_update_top.sv
// ----------------------------------------------------------------------------
// ldpc_variable_node_update_top
// sum-product variable node update: collects the edges of one variable node,
// then returns one extrinsic message per edge with the node posterior
// ----------------------------------------------------------------------------
//  channel  dir  payload                                        request
//  i_edge   in   check_msg, channel_llr, edge_tag, last_edge    one edge
//  o_res    out  var_msg, out_tag, node_llr, last_result        one edge result
//
//  edges are accepted while collecting; readout then walks the group one edge at
//  a time, a registered read of the edge buffer followed by the result stage
//  synchronous active-low reset clears the sequencer, count and sum; buffers
//  hold no reset value and only entries of the current group are read
//  i_edge is not ready during readout; o_res stalls hold the result register
//  and pause readout, the register lets the next buffer read overlap a stall
// ----------------------------------------------------------------------------
module ldpc_variable_node_update_top
    import ldpcvn_pkg::*;
#(
    parameter int MAX_DEGREE = 32,
    parameter int MSG_BITS   = 10,
    parameter int TAG_BITS   = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ldpcvn_in_if.sink     i_edge,
    ldpcvn_out_if.source  o_res
);

    localparam int IDX_W = $clog2(MAX_DEGREE);

    // command and status between sequencer and datapath
    t_dp_cmd    cmd;
    t_dp_status status;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] rd_idx;
    logic             in_ready;

    // sequencer: edge collection, then buffer readout one edge at a time
    ldpcvn_ctrl #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_edge.valid),
        .o_in_ready  (in_ready),
        .i_last_edge (i_edge.last_edge),
        .o_cmd       (cmd),
        .i_status    (status),
        .o_wr_idx    (wr_idx),
        .o_rd_idx    (rd_idx)
    );

    assign i_edge.ready = in_ready;

    // datapath: buffers, running sum, saturation and result register
    ldpcvn_datapath #(
        .MAX_DEGREE (MAX_DEGREE),
        .MSG_BITS   (MSG_BITS),
        .TAG_BITS   (TAG_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_wr_idx      (wr_idx),
        .i_rd_idx      (rd_idx),
        .i_check_msg   (i_edge.check_msg),
        .i_channel_llr (i_edge.channel_llr),
        .i_edge_tag    (i_edge.edge_tag),
        .o_valid       (o_res.valid),
        .i_ready       (o_res.ready),
        .o_var_msg     (o_res.var_msg),
        .o_out_tag     (o_res.out_tag),
        .o_node_llr    (o_res.node_llr),
        .o_last_result (o_res.last_result)
    );

endmodule

FILE: rtl/ldpcvn_datapath.sv
// ----------------------------------------------------------------------------
// ldpcvn_datapath
// edge buffers, running sum, result arithmetic and output register
// ----------------------------------------------------------------------------
module ldpcvn_datapath
    import ldpcvn_pkg::*;
#(
    parameter int MAX_DEGREE = 32,
    parameter int MSG_BITS   = 10,
    parameter int TAG_BITS   = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_dp_cmd                     i_cmd,
    output t_dp_status                  o_status,
    input  logic [$clog2(MAX_DEGREE)-1:0] i_wr_idx,
    input  logic [$clog2(MAX_DEGREE)-1:0] i_rd_idx,
    input  logic signed [MSG_BITS-1:0]  i_check_msg,
    input  logic signed [MSG_BITS-1:0]  i_channel_llr,
    input  logic        [TAG_BITS-1:0]  i_edge_tag,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [MSG_BITS-1:0]  o_var_msg,
    output logic        [TAG_BITS-1:0]  o_out_tag,
    output logic signed [NODE_BITS-1:0] o_node_llr,
    output logic                        o_last_result
);

    localparam int SUM_RAW = MSG_BITS + $clog2(MAX_DEGREE) + 3;
    localparam int SUM_W   = (SUM_RAW > NODE_BITS + 1) ? SUM_RAW : NODE_BITS + 1;
    localparam int EXT_W   = SUM_W - MSG_BITS;

    localparam logic signed [SUM_W-1:0] MSG_HI  = SUM_W'((1 << (MSG_BITS - 1)) - 1);
    localparam logic signed [SUM_W-1:0] MSG_LO  = SUM_W'(-(1 << (MSG_BITS - 1)));
    localparam logic signed [SUM_W-1:0] NODE_HI = SUM_W'((1 << (NODE_BITS - 1)) - 1);
    localparam logic signed [SUM_W-1:0] NODE_LO = SUM_W'(-(1 << (NODE_BITS - 1)));

    // edge buffers
    logic [MSG_BITS-1:0] r_msg_mem [MAX_DEGREE];
    logic [TAG_BITS-1:0] r_tag_mem [MAX_DEGREE];
    logic [MSG_BITS-1:0] r_rd_msg;
    logic [TAG_BITS-1:0] r_rd_tag;

    logic signed [SUM_W-1:0]    r_sum;
    logic signed [SUM_W-1:0]    r_total;
    logic signed [MSG_BITS-1:0] r_held;

    logic                        r_out_valid;
    logic signed [MSG_BITS-1:0]  r_var_msg;
    logic        [TAG_BITS-1:0]  r_out_tag;
    logic signed [NODE_BITS-1:0] r_node_llr;
    logic                        r_last;

    logic signed [SUM_W-1:0] msg_ext;
    logic signed [SUM_W-1:0] held_ext;
    logic signed [SUM_W-1:0] rd_ext;
    logic signed [SUM_W-1:0] diff;
    logic signed [MSG_BITS-1:0]  n_var_msg;
    logic signed [NODE_BITS-1:0] n_node_llr;

    assign msg_ext  = {{EXT_W{i_check_msg[MSG_BITS-1]}}, i_check_msg};
    assign held_ext = {{EXT_W{r_held[MSG_BITS-1]}}, r_held};
    assign rd_ext   = {{EXT_W{r_rd_msg[MSG_BITS-1]}}, r_rd_msg};
    assign diff     = r_total - rd_ext;

    always_comb begin
        if (diff > MSG_HI) begin
            n_var_msg = MSG_HI[MSG_BITS-1:0];
        end else if (diff < MSG_LO) begin
            n_var_msg = MSG_LO[MSG_BITS-1:0];
        end else begin
            n_var_msg = diff[MSG_BITS-1:0];
        end
        if (r_total > NODE_HI) begin
            n_node_llr = NODE_HI[NODE_BITS-1:0];
        end else if (r_total < NODE_LO) begin
            n_node_llr = NODE_LO[NODE_BITS-1:0];
        end else begin
            n_node_llr = r_total[NODE_BITS-1:0];
        end
    end

    // buffers: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_msg_mem[i_wr_idx] <= i_check_msg;
            r_tag_mem[i_wr_idx] <= i_edge_tag;
        end
        if (i_cmd.rd_en) begin
            r_rd_msg <= r_msg_mem[i_rd_idx];
            r_rd_tag <= r_tag_mem[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_held <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_sum <= '0;
            end else if (i_cmd.store) begin
                r_sum <= r_sum + msg_ext;
            end
            if (i_cmd.first) begin
                r_held <= i_channel_llr;
            end
        end
    end

    // posterior, registered from the held channel llr and the running sum
    always_ff @(posedge i_clk) begin
        r_total <= held_ext + r_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_var_msg  <= n_var_msg;
            r_out_tag  <= r_rd_tag;
            r_node_llr <= n_node_llr;
            r_last     <= i_cmd.out_last;
        end
    end

    assign o_status.out_free = !r_out_valid || i_ready;
    assign o_valid       = r_out_valid;
    assign o_var_msg     = r_var_msg;
    assign o_out_tag     = r_out_tag;
    assign o_node_llr    = r_node_llr;
    assign o_last_result = r_last;

endmodule

FILE: rtl/ldpcvn_ctrl.sv
// ----------------------------------------------------------------------------
// ldpcvn_ctrl
// sequencer for edge collection and result readout
// ----------------------------------------------------------------------------
module ldpcvn_ctrl
    import ldpcvn_pkg::*;
#(
    parameter int MAX_DEGREE = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_last_edge,
    output t_dp_cmd                       o_cmd,
    input  t_dp_status                    i_status,
    output logic [$clog2(MAX_DEGREE)-1:0] o_wr_idx,
    output logic [$clog2(MAX_DEGREE)-1:0] o_rd_idx
);

    localparam int IDX_W = $clog2(MAX_DEGREE);
    localparam int CNT_W = $clog2(MAX_DEGREE + 1);

    localparam logic [1:0] S_ACCEPT = 2'd0;
    localparam logic [1:0] S_READ   = 2'd1;
    localparam logic [1:0] S_EMIT   = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_rd_idx, n_rd_idx;

    logic accept;
    logic has_room;
    logic out_last;

    assign accept   = i_in_valid && (r_state == S_ACCEPT);
    assign has_room = r_count < CNT_W'(MAX_DEGREE);
    assign out_last = (CNT_W'(r_rd_idx) + 1'b1) == r_count;

    always_comb begin
        o_cmd.store    = accept && has_room;
        o_cmd.first    = accept && (r_count == '0);
        o_cmd.rd_en    = (r_state == S_READ);
        o_cmd.load_out = (r_state == S_EMIT) && i_status.out_free;
        o_cmd.out_last = out_last;
        o_cmd.clear    = (r_state == S_EMIT) && i_status.out_free && out_last;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_rd_idx = r_rd_idx;
        case (r_state)
            S_ACCEPT: begin
                if (accept) begin
                    if (has_room) begin
                        n_count = r_count + 1'b1;
                    end
                    if (i_last_edge) begin
                        n_rd_idx = '0;
                        n_state  = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    if (out_last) begin
                        n_count = '0;
                        n_state = S_ACCEPT;
                    end else begin
                        n_rd_idx = r_rd_idx + 1'b1;
                        n_state  = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_ACCEPT;
                n_count = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_ACCEPT;
            r_count  <= '0;
            r_rd_idx <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_idx <= n_rd_idx;
        end
    end

    assign o_in_ready = (r_state == S_ACCEPT);
    assign o_wr_idx   = r_count[IDX_W-1:0];
    assign o_rd_idx   = r_rd_idx;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_DEGREE))
        else $error("edge count beyond buffer depth");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (CNT_W'(r_rd_idx) < r_count))
        else $error("read index past buffered edges");

    a_run_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clear |=> (r_count == '0 && r_state == S_ACCEPT))
        else $error("run did not return to edge collection");

    a_load_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (r_state == S_EMIT && i_status.out_free))
        else $error("result loaded outside the emit step");

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the ldpc variable node update: groups of edge
// requests go in, and each closed group is checked against a predicted run of
// extrinsic messages with the node posterior, one result request per edge
// ----------------------------------------------------------------------------
module tb_top;
    import ldpcvn_pkg::*;

    localparam int MSG_W  = 10;
    localparam int TAG_W  = 12;
    localparam int DEGREE = 32;

    // one edge request as queued for the driver
    // gap_after: idle cycles after this edge is taken
    // drain_first: hold this edge back until every pending result is out
    typedef struct {
        logic signed [MSG_W-1:0] check_msg;
        logic signed [MSG_W-1:0] channel_llr;
        logic        [TAG_W-1:0] edge_tag;
        logic                    last_edge;
        int                      gap_after;
        bit                      drain_first;
    } t_edge_job;

    // one predicted result request
    typedef struct {
        logic signed [MSG_W-1:0]     var_msg;
        logic        [TAG_W-1:0]     out_tag;
        logic signed [NODE_BITS-1:0] node_llr;
        logic                        last_result;
    } t_vn_result;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #5 i_clk = ~i_clk;

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // channels and the block
    ldpcvn_in_if  #(.MSG_BITS(MSG_W), .TAG_BITS(TAG_W)) edge_if ();
    ldpcvn_out_if #(.MSG_BITS(MSG_W), .TAG_BITS(TAG_W), .NODE_BITS(NODE_BITS)) res_if ();

    ldpc_variable_node_update_top #(
        .MAX_DEGREE (DEGREE),
        .MSG_BITS   (MSG_W),
        .TAG_BITS   (TAG_W)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_edge  (edge_if),
        .o_res   (res_if)
    );

    // driven copies of the block inputs, known from time zero
    logic                    edge_valid = 1'b0;
    logic signed [MSG_W-1:0] edge_msg   = '0;
    logic signed [MSG_W-1:0] edge_chan  = '0;
    logic        [TAG_W-1:0] edge_tag   = '0;
    logic                    edge_last  = 1'b0;
    logic                    res_ready  = 1'b0;

    assign edge_if.valid       = edge_valid;
    assign edge_if.check_msg   = edge_msg;
    assign edge_if.channel_llr = edge_chan;
    assign edge_if.edge_tag    = edge_tag;
    assign edge_if.last_edge   = edge_last;
    assign res_if.ready        = res_ready;

    // stimulus and expectations
    t_edge_job  edge_jobs[$];
    t_vn_result outgoing_due[$];
    int         results_due  = 0;   // results predicted so far, updated at the edge
    int         results_seen = 0;   // results taken so far, updated at the edge
    int         fail_cnt     = 0;

    // predictor copy of the variable node state
    logic signed [MSG_W-1:0] vn_msgs[DEGREE];
    logic        [TAG_W-1:0] vn_tags[DEGREE];
    int                      vn_count = 0;
    int                      vn_sum   = 0;
    int                      vn_chan  = 0;

    function automatic int clamp_llr(int x, int bits);
        int hi;
        int lo;
        hi = (1 << (bits - 1)) - 1;
        lo = -hi - 1;
        if (x > hi) return hi;
        if (x < lo) return lo;
        return x;
    endfunction

    function void report_fault(string what);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display("mismatch at %0t: %s", $realtime, what);
    endfunction

    // takes one accepted edge; on the last edge of a group queues one result
    // per buffered edge, in arrival order
    task automatic update_variable_node(t_edge_job e);
        t_vn_result r;
        int         total;
        if (vn_count == 0)
            vn_chan = int'(e.channel_llr);   // later edges' channel llr is ignored
        // a full buffer drops further edges, but a dropped last edge still closes
        if (vn_count < DEGREE) begin
            vn_msgs[vn_count] = e.check_msg;
            vn_tags[vn_count] = e.edge_tag;
            vn_sum += int'(e.check_msg);
            vn_count++;
        end
        if (e.last_edge) begin
            total = vn_chan + vn_sum;
            for (int k = 0; k < vn_count; k++) begin
                r.var_msg     = MSG_W'(clamp_llr(total - int'(vn_msgs[k]), MSG_W));
                r.out_tag     = vn_tags[k];
                r.node_llr    = NODE_BITS'(clamp_llr(total, NODE_BITS));
                r.last_result = (k == vn_count - 1);
                outgoing_due = {outgoing_due, r};
            end
            results_due <= results_due + vn_count;
            vn_count = 0;
            vn_sum   = 0;
            vn_chan  = 0;
        end
    endtask

    // driver: presents queued edges, idles for each edge's gap afterwards
    t_edge_job on_wire;
    int        idle_left = 0;

    always @(posedge i_clk) begin
        logic taken;
        int   idle;
        if (!i_rst_n) begin
            edge_valid <= 1'b0;
            idle_left  <= 0;
        end else begin
            taken = edge_valid && edge_if.ready;
            idle  = idle_left;
            if (taken) begin
                update_variable_node(on_wire);
                idle = on_wire.gap_after;
            end
            if (edge_valid && !taken) begin
                // request still waiting, keep it on the wire
            end else if (idle > 0) begin
                edge_valid <= 1'b0;
                idle_left  <= idle - 1;
            end else if (edge_jobs.size() != 0 &&
                         (!edge_jobs[0].drain_first ||
                          (!taken && results_due == results_seen))) begin
                on_wire = edge_jobs.pop_front();
                edge_valid <= 1'b1;
                edge_msg   <= on_wire.check_msg;
                edge_chan  <= on_wire.channel_llr;
                edge_tag   <= on_wire.edge_tag;
                edge_last  <= on_wire.last_edge;
                idle_left  <= 0;
            end else begin
                // nothing ready to send, or waiting for the results to drain
                edge_valid <= 1'b0;
                idle_left  <= 0;
            end
        end
    end

    // long hold-off of the result side while edges keep coming, so the
    // block stays in readout and keeps ready low on its input
    int hold_left = 0;
    bit hold_used = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end else if (!hold_used && results_seen >= 12 && results_due > results_seen) begin
            hold_left <= 400;
            hold_used <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor: checks each result request, then stalls a random while
    int stall_left = 0;
    bit rx_calm    = 1'b0;   // stretches where ready stays high

    always @(posedge i_clk) begin
        t_vn_result want;
        int         wait_n;
        if (!i_rst_n) begin
            res_ready  <= 1'b0;
            stall_left <= 0;
        end else begin
            wait_n = stall_left;
            if (res_if.valid && res_ready) begin
                results_seen <= results_seen + 1;
                if (outgoing_due.size() == 0) begin
                    report_fault($sformatf("unexpected result msg %0d tag %0d node %0d last %0b",
                                           res_if.var_msg, res_if.out_tag,
                                           res_if.node_llr, res_if.last_result));
                end else begin
                    want = outgoing_due.pop_front();
                    if (res_if.var_msg !== want.var_msg || res_if.out_tag !== want.out_tag ||
                        res_if.node_llr !== want.node_llr ||
                        res_if.last_result !== want.last_result)
                        report_fault($sformatf(
                            "exp msg %0d tag %0d node %0d last %0b, got %0d %0d %0d %0b",
                            want.var_msg, want.out_tag, want.node_llr, want.last_result,
                            res_if.var_msg, res_if.out_tag, res_if.node_llr,
                            res_if.last_result));
                end
                wait_n = rx_calm ? 0 : $urandom_range(0, 14);
                if ($urandom_range(0, 39) == 0)
                    rx_calm <= !rx_calm;
            end else if (wait_n > 0) begin
                wait_n--;
            end
            stall_left <= wait_n;
            res_ready  <= (wait_n == 0) && (hold_left == 0);
        end
    end

    // stimulus, end of run
    task automatic add_edge(int msg, int chan, int tag, bit last, bit drain, bit calm);
        t_edge_job j;
        j.check_msg   = MSG_W'(msg);
        j.channel_llr = MSG_W'(chan);
        j.edge_tag    = TAG_W'(tag);
        j.last_edge   = last;
        j.gap_after   = calm ? 0 : $urandom_range(0, 14);
        j.drain_first = drain;
        edge_jobs = {edge_jobs, j};
    endtask

    initial begin
        int n_items;
        int grp;
        int size;
        int mode;
        int v;
        bit calm;
        int waited;

        // directed groups
        // single edges at both extremes, tags at their extremes
        add_edge(511, 511, 0, 1'b1, 1'b0, 1'b0);
        add_edge(-512, -512, 4095, 1'b1, 1'b0, 1'b0);
        // a group of two requests, outgoing message saturates low; later channel llr ignored
        add_edge(-512, -512, 'hAAA, 1'b0, 1'b0, 1'b0);
        add_edge(-512, 511, 'h555, 1'b1, 1'b0, 1'b0);
        // a group of five full-scale requests, posterior saturates high
        for (int k = 0; k < 5; k++)
            add_edge(511, (k == 0) ? 511 : -512, k + 1, k == 4, 1'b0, 1'b1);
        // a group of five requests at negative full scale, posterior saturates low
        for (int k = 0; k < 5; k++)
            add_edge(-512, (k == 0) ? -512 : 511, 4090 + k, k == 4, 1'b0, 1'b0);
        // small values around zero, sent only once the pipe is empty
        add_edge(0, 0, 7, 1'b0, 1'b1, 1'b0);
        add_edge(1, 300, 8, 1'b0, 1'b0, 1'b0);
        add_edge(-1, -300, 9, 1'b1, 1'b0, 1'b0);
        // messages that cancel out
        add_edge(300, -100, 100, 1'b0, 1'b0, 1'b0);
        add_edge(-300, 200, 101, 1'b1, 1'b0, 1'b0);

        // random groups: mostly small degrees, a few full and overfull ones
        n_items = 0;
        grp     = 0;
        while (n_items < 140) begin
            v = $urandom_range(0, 19);
            if (grp == 2 || v == 0)
                size = $urandom_range(DEGREE + 1, DEGREE + 4);
            else if (grp == 5 || v == 1)
                size = DEGREE;
            else if (v <= 4)
                size = $urandom_range(9, 20);
            else
                size = $urandom_range(1, 8);
            mode = $urandom_range(0, 3);
            calm = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < size; k++) begin
                case (mode)
                    2:       v = $urandom_range(400, 511);
                    3:       v = -int'($urandom_range(400, 512));
                    default: v = $urandom_range(0, 1023);
                endcase
                add_edge(v, $urandom_range(0, 1023), $urandom_range(0, 4095), k == size - 1,
                         k == 0 && (grp == 1 || $urandom_range(0, 11) == 0), calm);
            end
            n_items += size;
            grp++;
        end

        // wait for every edge to be taken, then for the results to drain
        while (edge_jobs.size() != 0 || edge_valid)
            @(posedge i_clk);
        waited = 0;
        while (results_due != results_seen && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (100) @(posedge i_clk);
        if (outgoing_due.size() != 0)
            report_fault($sformatf("%0d expected results never came", outgoing_due.size()));

        if (fail_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #3000000;
        $display("FAIL");
        $finish;
    end

endmodule
